[rtl/cca_pkg.sv]
// Shared types, constants and calendar helpers for the cron calendar alarm.
package cca_pkg;

    localparam int unsigned CFG_DATA_W = 60;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TICK_W     = 21;

    localparam logic [TICK_W-1:0] MAX_TICKS = 21'd1054080;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_MASK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNS     = 3'd5;

    // request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [4:0] LAST_HOUR    = 5'd23;
    localparam logic [5:0] LAST_MINUTE  = 6'd59;
    localparam logic [3:0] LAST_MONTH   = 4'd12;
    localparam logic [2:0] LAST_WEEKDAY = 3'd6;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
    } t_cal;

    typedef struct packed {
        logic        mode;
        t_cal        cal;
    } t_req;

    typedef struct packed {
        logic        match;
        t_cal        cal;
        logic [6:0]  run_number;
        logic        done;
        logic        time_error;
    } t_rsp;

    // Gregorian leap rule; y/100 via reciprocal 5243/2^19 (exact for 12-bit y)
    function automatic logic is_leap(input logic [11:0] y);
        logic [24:0] prod;
        logic [5:0]  q;
        logic [11:0] hundreds;
        logic [11:0] rem;
        prod     = 25'(y) * 25'd5243;
        q        = prod[24:19];
        hundreds = 12'({q, 6'b0}) + 12'({q, 5'b0}) + 12'({q, 2'b0});
        rem      = y - hundreds;
        return (y[1:0] == 2'b00) && ((rem != 12'd0) || (q[1:0] == 2'b00));
    endfunction

    // 0 for a month code outside 1..12
    function automatic logic [4:0] month_len(input logic [11:0] y, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = is_leap(y) ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[rtl/cron_calendar_alarm.sv]
// Cron calendar alarm: minute calendar, cron mask match and run counting.
//
// Each request either loads a start time (mode 0) or advances the calendar by
// one minute and tests it against the five cron masks (mode 1). Requests are
// registered on input, processed in a single combinational step against the
// calendar and counter registers, and the response is registered on output.
// One request per cycle is taken while responses are drained; a stalled
// response holds the next request in the input register. The calendar state
// updates with the response register, so back-to-back ticks see each other's
// result. o_in_ready is high while the input register is empty or its request
// moves into a free or draining response register, so draining a response
// does not block the next request from entering the input register.
// A load with a bad date or time (day 0 or past the month's end, month outside
// 1..12, hour above 23, minute above 59, weekday above 6) is rejected with
// o_time_error set and leaves the state alone; the weekday is not checked
// against the date. Years wrap at 4095. Matching stops and o_done_res rises
// once max_runs matches are counted or MAX_TICKS ticks are tested; the
// calendar keeps advancing. Day of month and weekday are ANDed. Registers are
// written through i_cfg_wr_en / i_cfg_idx / i_cfg_data; the user must write
// only while no request is in flight (not enforced). Indexes past max_runs are
// ignored. Reset gives 1970-01-01 00:00 Thursday, all masks 0 and max_runs 5.
module cron_calendar_alarm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_wr_en,
    input  logic [cca_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cca_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [11:0]                   i_load_year,
    input  logic [3:0]                    i_load_month,
    input  logic [4:0]                    i_load_day,
    input  logic [4:0]                    i_load_hour,
    input  logic [5:0]                    i_load_minute,
    input  logic [2:0]                    i_load_weekday,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_match,
    output logic [11:0]                   o_now_year,
    output logic [3:0]                    o_now_month,
    output logic [4:0]                    o_now_day,
    output logic [4:0]                    o_now_hour,
    output logic [5:0]                    o_now_minute,
    output logic [2:0]                    o_now_weekday,
    output logic [6:0]                    o_run_number,
    output logic                          o_done_res,
    output logic                          o_time_error
);

    // configuration
    logic [59:0] r_minute_mask;
    logic [23:0] r_hour_mask;
    logic [30:0] r_day_mask;
    logic [11:0] r_month_mask;
    logic [6:0]  r_weekday_mask;
    logic [6:0]  r_max_runs;

    // state
    cca_pkg::t_cal          r_cal, n_cal;
    logic [6:0]             r_runs, n_runs;
    logic [cca_pkg::TICK_W-1:0] r_ticks, n_ticks;

    // pipeline registers
    logic          r_in_valid;
    cca_pkg::t_req r_in;
    logic          r_out_valid;
    cca_pkg::t_rsp r_out, n_out;

    logic          fire;      // input register moves into the response register
    cca_pkg::t_cal adv;
    cca_pkg::t_cal ld;
    logic [4:0]    cur_len;
    logic          ld_bad;
    logic          done_pre;
    logic          hit;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_mask  <= '0;
            r_hour_mask    <= '0;
            r_day_mask     <= '0;
            r_month_mask   <= '0;
            r_weekday_mask <= '0;
            r_max_runs     <= 7'd5;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                cca_pkg::CFG_MINUTE_MASK:  r_minute_mask  <= i_cfg_data[59:0];
                cca_pkg::CFG_HOUR_MASK:    r_hour_mask    <= i_cfg_data[23:0];
                cca_pkg::CFG_DAY_MASK:     r_day_mask     <= i_cfg_data[30:0];
                cca_pkg::CFG_MONTH_MASK:   r_month_mask   <= i_cfg_data[11:0];
                cca_pkg::CFG_WEEKDAY_MASK: r_weekday_mask <= i_cfg_data[6:0];
                cca_pkg::CFG_MAX_RUNS:     r_max_runs     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // one-minute advance of the current calendar
    always_comb begin
        adv     = r_cal;
        cur_len = cca_pkg::month_len(r_cal.year, r_cal.month);
        if (r_cal.minute >= cca_pkg::LAST_MINUTE) begin
            adv.minute = '0;
            if (r_cal.hour >= cca_pkg::LAST_HOUR) begin
                adv.hour    = '0;
                adv.weekday = (r_cal.weekday >= cca_pkg::LAST_WEEKDAY) ? 3'd0
                                                                         : r_cal.weekday + 3'd1;
                if (r_cal.day >= cur_len) begin
                    adv.day = 5'd1;
                    if (r_cal.month >= cca_pkg::LAST_MONTH) begin
                        adv.month = 4'd1;
                        adv.year  = r_cal.year + 12'd1;
                    end else begin
                        adv.month = r_cal.month + 4'd1;
                    end
                end else begin
                    adv.day = r_cal.day + 5'd1;
                end
            end else begin
                adv.hour = r_cal.hour + 5'd1;
            end
        end else begin
            adv.minute = r_cal.minute + 6'd1;
        end
    end

    assign ld     = r_in.cal;
    assign ld_bad = (ld.day == 5'd0)
                 || (ld.day > cca_pkg::month_len(ld.year, ld.month))
                 || (ld.hour > cca_pkg::LAST_HOUR)
                 || (ld.minute > cca_pkg::LAST_MINUTE)
                 || (ld.weekday > cca_pkg::LAST_WEEKDAY);

    assign done_pre = (r_runs >= r_max_runs) || (r_ticks >= cca_pkg::MAX_TICKS);

    assign hit = r_minute_mask[adv.minute]
              && r_hour_mask[adv.hour]
              && r_day_mask[adv.day - 5'd1]
              && r_month_mask[adv.month - 4'd1]
              && r_weekday_mask[adv.weekday];

    // next state and response
    always_comb begin
        n_cal   = r_cal;
        n_runs  = r_runs;
        n_ticks = r_ticks;
        n_out   = '0;
        if (r_in.mode == cca_pkg::MODE_LOAD) begin
            if (ld_bad) begin
                n_out.time_error = 1'b1;
            end else begin
                n_cal   = ld;
                n_runs  = '0;
                n_ticks = '0;
            end
        end else begin
            n_cal = adv;
            if (!done_pre) begin
                n_ticks = r_ticks + 21'd1;
                if (hit) begin
                    n_runs      = r_runs + 7'd1;
                    n_out.match = 1'b1;
                end
            end
        end
        n_out.cal        = n_cal;
        n_out.run_number = n_runs;
        n_out.done       = (n_runs >= r_max_runs) || (n_ticks >= cca_pkg::MAX_TICKS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal       <= '{year: 12'd1970, month: 4'd1, day: 5'd1,
                             hour: 5'd0, minute: 6'd0, weekday: 3'd4};
            r_runs      <= '0;
            r_ticks     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_cal       <= n_cal;
                r_runs      <= n_runs;
                r_ticks     <= n_ticks;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= '{mode: i_mode,
                      cal: '{year: i_load_year, month: i_load_month, day: i_load_day,
                             hour: i_load_hour, minute: i_load_minute,
                             weekday: i_load_weekday}};
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match       = r_out.match;
    assign o_now_year    = r_out.cal.year;
    assign o_now_month   = r_out.cal.month;
    assign o_now_day     = r_out.cal.day;
    assign o_now_hour    = r_out.cal.hour;
    assign o_now_minute  = r_out.cal.minute;
    assign o_now_weekday = r_out.cal.weekday;
    assign o_run_number  = r_out.run_number;
    assign o_done_res    = r_out.done;
    assign o_time_error  = r_out.time_error;

endmodule

[rtl/cca_checker.sv]
// Port-level checker for the cron calendar alarm, bound to the top level.
module cca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_match,
    input logic [11:0] o_now_year,
    input logic [2:0]  o_now_weekday,
    input logic [6:0]  o_run_number,
    input logic        o_time_error
);

    // stalled response holds its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_match)
            && $stable(o_now_year) && $stable(o_run_number))
        else $error("response changed while stalled");

    // no response straight out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    // a rejected load never reports a match
    a_err_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_time_error && o_match))
        else $error("match with time error");

    // a match always counts a run
    a_match_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match |-> o_run_number != 7'd0)
        else $error("match without run count");

    // weekday stays in range
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_now_weekday <= 3'd6)
        else $error("weekday out of range");

endmodule

bind cron_calendar_alarm cca_checker u_cca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_match       (o_match),
    .o_now_year    (o_now_year),
    .o_now_weekday (o_now_weekday),
    .o_run_number  (o_run_number),
    .o_time_error  (o_time_error)
);
